### hw/rtl/dip_pkg.sv
package dip_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_TRAIL,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic [31:0] acc;
    logic [1:0]  parts_seen;
  } parse_state_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
    logic [2:0]  part_count;
  } parse_result_t;

  typedef struct packed {
    logic       en;
    logic [1:0] idx;
  } part_write_t;

  typedef logic [2:0][31:0] part_array_t;

  localparam parse_state_t ST_RESET = '{
    phase:      PH_START,
    radix:      RX_DEC,
    acc:        32'd0,
    parts_seen: 2'd0
  };

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [31:0] MAX_PART24 = 32'h00ff_ffff;
  localparam logic [31:0] MAX_PART16 = 32'h0000_ffff;
  localparam logic [31:0] MAX_PART8  = 32'h0000_00ff;

  localparam logic [1:0] LAST_DOT_PARTS = 2'd3;

endpackage

### hw/rtl/dip_ifs.sv
interface dip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface dip_result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] address;
  logic [2:0]  part_count;

  modport source (output valid, output valid_res, output address, output part_count,
                  input ready);
  modport sink (input valid, input valid_res, input address, input part_count,
                output ready);
endinterface

### hw/rtl/dip_step.sv
module dip_step
  import dip_pkg::*;
(
  input  logic [7:0]    ch,
  input  parse_state_t  st,
  input  part_array_t   parts,
  output parse_state_t  st_next,
  output part_write_t   wr,
  output parse_result_t res,
  output logic          is_nul
);

  logic        is_dec;
  logic        is_lo;
  logic        is_up;
  logic        is_dot;
  logic        is_space;
  logic        is_x;
  radix_t      eff_radix;
  logic        dig_takes;
  logic        dot_ok;
  logic [3:0]  digit;
  logic [31:0] acc_dec;
  logic [31:0] acc_oct;
  logic [31:0] acc_hex;
  logic [31:0] acc_step;
  phase_t      digits_phase;

  phase_t      phase_next;
  radix_t      radix_next;
  logic [31:0] acc_next;
  logic [1:0]  parts_next;

  logic        fin_ok;
  logic [31:0] fin_val;
  logic [2:0]  fin_count;

  assign is_nul   = (ch == CH_NUL);
  assign is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_lo    = (ch >= CH_LO_A) && (ch <= CH_LO_F);
  assign is_up    = (ch >= CH_UP_A) && (ch <= CH_UP_F);
  assign is_dot   = (ch == CH_DOT);
  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_x     = (ch == CH_LO_X) || (ch == CH_UP_X);

  // The first digit after a leading zero is already read as octal.
  assign eff_radix = (st.phase == PH_ZERO) ? RX_OCT : st.radix;
  assign dig_takes = is_dec || ((eff_radix == RX_HEX) && (is_lo || is_up));
  assign dot_ok    = is_dot && (st.parts_seen != LAST_DOT_PARTS);

  // Letters a..f and A..F share their low three bits, 1..6.
  assign digit = is_dec ? ch[3:0] : (4'(ch[2:0]) + 4'd9);

  assign acc_dec = {st.acc[28:0], 3'b000} + {st.acc[30:0], 1'b0} + {28'd0, digit};
  assign acc_oct = {st.acc[28:0], 3'b000} + {28'd0, digit};
  assign acc_hex = {st.acc[27:0], digit};

  always_comb begin
    unique case (eff_radix)
      RX_HEX:  acc_step = acc_hex;
      RX_OCT:  acc_step = acc_oct;
      default: acc_step = acc_dec;
    endcase
  end

  always_comb begin
    priority if (dig_takes) begin
      digits_phase = PH_DIGITS;
    end else if (is_dot) begin
      digits_phase = dot_ok ? PH_START : PH_ERR;
    end else if (is_space) begin
      digits_phase = PH_TRAIL;
    end else begin
      digits_phase = PH_ERR;
    end
  end

  // Next phase.
  always_comb begin
    if (is_nul) begin
      phase_next = PH_START;
    end else begin
      unique case (st.phase)
        PH_START: begin
          if (ch == CH_ZERO) begin
            phase_next = PH_ZERO;
          end else if (is_dec) begin
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_ZERO:   phase_next = is_x ? PH_DIGITS : digits_phase;
        PH_DIGITS: phase_next = digits_phase;
        PH_TRAIL:  phase_next = PH_TRAIL;
        default:   phase_next = PH_ERR;
      endcase
    end
  end

  // Accumulator, radix, part count and the write of a finished part.
  always_comb begin
    acc_next   = st.acc;
    radix_next = st.radix;
    parts_next = st.parts_seen;
    wr         = '0;
    if (is_nul) begin
      acc_next   = ST_RESET.acc;
      radix_next = ST_RESET.radix;
      parts_next = ST_RESET.parts_seen;
    end else begin
      unique case (st.phase)
        PH_START: begin
          if (is_dec) begin
            acc_next   = {28'd0, ch[3:0]};
            radix_next = RX_DEC;
          end
        end
        PH_ZERO, PH_DIGITS: begin
          if ((st.phase == PH_ZERO) && is_x) begin
            radix_next = RX_HEX;
          end else begin
            if (st.phase == PH_ZERO) begin
              radix_next = RX_OCT;
            end
            if (dig_takes) begin
              acc_next = acc_step;
            end else if (dot_ok) begin
              wr.en      = 1'b1;
              wr.idx     = st.parts_seen;
              parts_next = st.parts_seen + 2'd1;
              acc_next   = '0;
              radix_next = RX_DEC;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign st_next = '{phase: phase_next, radix: radix_next, acc: acc_next,
                     parts_seen: parts_next};

  // Result of the text, used only when the character is NUL.
  always_comb begin
    fin_count = {1'b0, st.parts_seen} + 3'd1;
    fin_ok    = (st.phase == PH_ZERO) || (st.phase == PH_DIGITS) ||
                (st.phase == PH_TRAIL);
    fin_val   = st.acc;
    unique case (st.parts_seen)
      2'd0: begin
      end
      2'd1: begin
        if ((st.acc > MAX_PART24) || (parts[0] > MAX_PART8)) begin
          fin_ok = 1'b0;
        end
        fin_val = st.acc | {parts[0][7:0], 24'd0};
      end
      2'd2: begin
        if ((st.acc > MAX_PART16) || (parts[0] > MAX_PART8) || (parts[1] > MAX_PART8)) begin
          fin_ok = 1'b0;
        end
        fin_val = st.acc | {parts[0][7:0], parts[1][7:0], 16'd0};
      end
      default: begin
        if ((st.acc > MAX_PART8) || (parts[0] > MAX_PART8) || (parts[1] > MAX_PART8) ||
            (parts[2] > MAX_PART8)) begin
          fin_ok = 1'b0;
        end
        fin_val = st.acc | {parts[0][7:0], parts[1][7:0], parts[2][7:0], 8'd0};
      end
    endcase
    res.valid_res  = fin_ok;
    res.address    = fin_ok ? fin_val : '0;
    res.part_count = fin_ok ? fin_count : '0;
  end

endmodule

### hw/rtl/dotted_ipv4_text_parser.sv
// Takes one character beat per cycle unless its two-entry output stage is
// full, with no bubbles between texts. A NUL beat's result is registered
// into that stage, which lets characters flow while a result is stalled;
// other characters produce no result and only update the parse state.
// Synchronous active-high reset clears the parse state and output valids;
// the stored earlier parts are not reset and are written before use.
module dotted_ipv4_text_parser
  import dip_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  dip_char_if.sink       chars,
  dip_result_if.source   result
);

  parse_state_t  st;
  parse_state_t  st_next;
  part_write_t   wr;
  parse_result_t res;
  logic          is_nul;
  logic          accept;
  logic          push;
  logic [31:0]   earlier_parts [3];
  part_array_t   parts;

  logic          out_valid;
  parse_result_t out_data;
  logic          skid_valid;
  parse_result_t skid_data;

  assign parts = {earlier_parts[2], earlier_parts[1], earlier_parts[0]};

  dip_step u_step (
    .ch      (chars.ch),
    .st      (st),
    .parts   (parts),
    .st_next (st_next),
    .wr      (wr),
    .res     (res),
    .is_nul  (is_nul)
  );

  assign chars.ready = !skid_valid;
  assign accept      = chars.valid && chars.ready;
  assign push        = accept && is_nul;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr.en) begin
      earlier_parts[wr.idx] <= st.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.valid_res  = out_data.valid_res;
  assign result.address    = out_data.address;
  assign result.part_count = out_data.part_count;

endmodule

### hw/rtl/dip_checker.sv
module dip_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  ch,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [31:0] address,
  input logic [2:0]  part_count
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(valid_res) && $stable(address) &&
                                $stable(part_count))
    else $error("stalled result beat changed");

  // A new result appears only after a NUL character beat was taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (ch == 8'h00)))
    else $error("result beat without a terminating NUL");

  // A rejected text reports zero address and zero parts.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> (address == 32'd0) && (part_count == 3'd0))
    else $error("invalid result carries data");

  // An accepted text has one to four parts.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> (part_count != 3'd0) && (part_count <= 3'd4))
    else $error("part count out of range");

endmodule

bind dotted_ipv4_text_parser dip_checker u_dip_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .ch         (chars.ch),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .valid_res  (result.valid_res),
  .address    (result.address),
  .part_count (result.part_count)
);

### bench/dotted_ipv4_text_parser_tb.sv
`timescale 1ns / 100ps

module dotted_ipv4_text_parser_tb;
  import dip_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  logic clk;
  logic rst;

  dip_char_if   chars_if ();
  dip_result_if result_if ();

  dotted_ipv4_text_parser uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned mismatches;

  // Shadow of the parser state for the text now being received.
  phase_t      txt_phase;
  radix_t      txt_radix;
  logic [31:0] part_acc;
  logic [31:0] done_parts [3];
  logic [1:0]  dots_seen;

  parse_result_t expected_addresses [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("dotted_ipv4_text_parser_tb: errors");
    $finish;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_text_state();
    txt_phase = PH_START;
    txt_radix = RX_DEC;
    part_acc  = 32'd0;
    dots_seen = 2'd0;
  endtask

  task automatic take_part_char(input logic [7:0] c);
    logic [31:0] cv;
    cv = {24'd0, c};
    if (is_digit(c)) begin
      case (txt_radix)
        RX_HEX:  part_acc = part_acc * 32'd16 + (cv - {24'd0, CH_ZERO});
        RX_OCT:  part_acc = part_acc * 32'd8 + (cv - {24'd0, CH_ZERO});
        default: part_acc = part_acc * 32'd10 + (cv - {24'd0, CH_ZERO});
      endcase
    end else if (txt_radix == RX_HEX && c >= CH_LO_A && c <= CH_LO_F) begin
      part_acc = (part_acc << 4) | (cv - {24'd0, CH_LO_A} + 32'd10);
    end else if (txt_radix == RX_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
      part_acc = (part_acc << 4) | (cv - {24'd0, CH_UP_A} + 32'd10);
    end else if (c == CH_DOT) begin
      if (dots_seen == LAST_DOT_PARTS) begin
        txt_phase = PH_ERR;
      end else begin
        done_parts[dots_seen] = part_acc;
        dots_seen = dots_seen + 2'd1;
        part_acc  = 32'd0;
        txt_radix = RX_DEC;
        txt_phase = PH_START;
      end
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      txt_phase = PH_TRAIL;
    end else begin
      txt_phase = PH_ERR;
    end
  endtask

  task automatic close_text();
    parse_result_t res;
    logic [31:0]   v;
    logic          ok;
    v  = part_acc;
    ok = txt_phase == PH_ZERO || txt_phase == PH_DIGITS || txt_phase == PH_TRAIL;
    if (ok) begin
      case (dots_seen)
        2'd1: begin
          if (v > MAX_PART24 || done_parts[0] > MAX_PART8) ok = 1'b0;
          else v = v | (done_parts[0] << 24);
        end
        2'd2: begin
          if (v > MAX_PART16 || done_parts[0] > MAX_PART8 || done_parts[1] > MAX_PART8)
            ok = 1'b0;
          else v = v | (done_parts[0] << 24) | (done_parts[1] << 16);
        end
        2'd3: begin
          if (v > MAX_PART8 || done_parts[0] > MAX_PART8 || done_parts[1] > MAX_PART8 ||
              done_parts[2] > MAX_PART8)
            ok = 1'b0;
          else v = v | (done_parts[0] << 24) | (done_parts[1] << 16) | (done_parts[2] << 8);
        end
        default: ;
      endcase
    end
    res.valid_res  = ok;
    res.address    = ok ? v : 32'd0;
    res.part_count = ok ? {1'b0, dots_seen} + 3'd1 : 3'd0;
    expected_addresses.push_back(res);
    clear_text_state();
  endtask

  task automatic advance_parser(input logic [7:0] c);
    if (c == CH_NUL) begin
      close_text();
    end else begin
      case (txt_phase)
        PH_START: begin
          if (c == CH_ZERO) begin
            part_acc  = 32'd0;
            txt_phase = PH_ZERO;
          end else if (is_digit(c)) begin
            part_acc  = {24'd0, c} - {24'd0, CH_ZERO};
            txt_radix = RX_DEC;
            txt_phase = PH_DIGITS;
          end else begin
            txt_phase = PH_ERR;
          end
        end
        PH_ZERO: begin
          txt_phase = PH_DIGITS;
          if (c == CH_LO_X || c == CH_UP_X) begin
            txt_radix = RX_HEX;
          end else begin
            txt_radix = RX_OCT;
            take_part_char(c);
          end
        end
        PH_DIGITS: take_part_char(c);
        PH_TRAIL:  ;
        default:   txt_phase = PH_ERR;
      endcase
    end
  endtask

  // Presents one character beat and returns at the falling edge after it is taken.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    advance_parser(c);
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic terminate);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    if (terminate) send_char(CH_NUL);
  endtask

  task automatic hold_until_drained();
    chars_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_addresses.size() != 0) @(negedge clk);
  endtask

  task automatic add_part(ref logic [7:0] q [$], input logic [31:0] val, input radix_t rx);
    logic [7:0]  digs [$];
    logic [31:0] v;
    logic [31:0] d;
    logic [31:0] base;
    base = (rx == RX_HEX) ? 32'd16 : (rx == RX_OCT) ? 32'd8 : 32'd10;
    v = val;
    while (v != 0) begin
      d = v % base;
      v = v / base;
      if (d < 10) digs.push_front(CH_ZERO + d[7:0]);
      else digs.push_front(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + d[7:0] - 8'd10);
    end
    // Octal parts sometimes carry an 8 or a 9, which the parser takes at face value.
    if (rx == RX_OCT && digs.size() != 0 && $urandom_range(0, 7) == 0)
      digs[$urandom_range(0, digs.size() - 1)] = $urandom_range(0, 1) ? CH_NINE : CH_NINE - 8'd1;
    case (rx)
      RX_DEC: if (digs.size() == 0) digs.push_back(CH_ZERO);
      RX_OCT: digs.push_front(CH_ZERO);
      default: begin
        if (digs.size() == 0 ? $urandom_range(0, 1) : $urandom_range(0, 3) == 0)
          digs.push_front(CH_ZERO);
        digs.push_front($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        digs.push_front(CH_ZERO);
      end
    endcase
    q = {q, digs};
  endtask

  task automatic build_address(ref logic [7:0] q [$]);
    int unsigned n;
    int unsigned i;
    int unsigned offset;
    logic [31:0] lim;
    logic [31:0] val;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      if (i < n - 1) lim = MAX_PART8;
      else if (n == 1) lim = 32'hffff_ffff;
      else if (n == 2) lim = MAX_PART24;
      else if (n == 3) lim = MAX_PART16;
      else lim = MAX_PART8;
      case ($urandom_range(0, 19))
        0:       val = 32'd0;
        1:       val = lim;
        2:       val = lim + 32'd1;
        3:       val = $urandom;
        default: val = $urandom_range(0, lim);
      endcase
      if (i > 0) q.push_back(CH_DOT);
      add_part(q, val, radix_t'($urandom_range(0, 2)));
    end
    if ($urandom_range(0, 6) == 0) begin
      offset = $urandom_range(0, 5);
      q.push_back(offset == 5 ? CH_SPACE : CH_TAB + offset[7:0]);
      repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_empty_and_stray();
    send_char(CH_NUL);
    send_char(8'hff);
    send_char(CH_NUL);
  endtask

  task automatic test_radix_prefixes();
    send_string("09", 1'b1);
    send_string("0X", 1'b1);
  endtask

  task automatic test_dot_limit();
    send_string("1.2.3.4.", 1'b1);
  endtask

  task automatic test_trailing_blank();
    send_string("7 z", 1'b1);
  endtask

  task automatic test_part_wrap();
    send_string("4294967297", 1'b1);
  endtask

  // The sender pauses until pending results drain, twice after a text and once mid-text.
  task automatic test_pause_for_results();
    send_string("1.2.3.4", 1'b1);
    hold_until_drained();
    send_string("10.", 1'b0);
    hold_until_drained();
    send_string("0.0.1", 1'b1);
    hold_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned budget);
    logic [7:0]  text [$];
    int unsigned sent;
    int unsigned kind;
    int unsigned pos;
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    sent = 0;
    while (sent < budget) begin
      text.delete();
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        build_address(text);
      end else if (kind < 17) begin
        build_address(text);
        pos = $urandom_range(0, text.size() - 1);
        if ($urandom_range(0, 1)) text[pos] = CH_DOT;
        else text.insert(pos, 8'($urandom_range(1, 255)));
      end else if (kind == 17) begin
        // Long digit runs can overflow the part and wrap.
        repeat ($urandom_range(10, 14)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(1, 255)));
      end
      text.push_back(CH_NUL);
      foreach (text[k]) send_char(text[k]);
      sent += text.size();
    end
  endtask

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin : check_results
    parse_result_t got;
    parse_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.valid_res  = result_if.valid_res;
      got.address    = result_if.address;
      got.part_count = result_if.part_count;
      if (expected_addresses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: valid_res=%0b address=%h part_count=%0d",
                   got.valid_res, got.address, got.part_count);
      end else begin
        want = expected_addresses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected valid_res=%0b address=%h part_count=%0d, %s",
                     want.valid_res, want.address, want.part_count,
                     $sformatf("got valid_res=%0b address=%h part_count=%0d",
                               got.valid_res, got.address, got.part_count));
        end
      end
    end
  end

  initial begin
    chars_if.valid  = 1'b0;
    chars_if.ch     = CH_NUL;
    result_if.ready = 1'b0;
    rst             = 1'b1;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    mismatches      = 0;
    done_parts      = '{32'd0, 32'd0, 32'd0};
    clear_text_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_and_stray();
    test_radix_prefixes();
    test_dot_limit();
    test_trailing_blank();
    test_part_wrap();
    test_pause_for_results();
    test_random_traffic(20, 78, 570);
    test_random_traffic(78, 20, 570);
    test_random_traffic(0, 0, 570);

    chars_if.valid <= 1'b0;
    while (expected_addresses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("dotted_ipv4_text_parser_tb: clean");
    end else begin
      $display("dotted_ipv4_text_parser_tb: errors");
    end
    $finish;
  end

endmodule
